@@ sv/dms_pkg.sv @@
// ----------------------------------------------------------------------------
// dms_pkg
// Shared types and constants of the door motor sequencer: field widths,
// configuration register indexes, door status codes and reset presets.
// ----------------------------------------------------------------------------
package dms_pkg;

    localparam int CMD_W    = 2;
    localparam int CFG_W    = 16;
    localparam int RETRY_W  = 4;
    localparam int STATUS_W = 8;
    localparam int CFG_IDX_W = 3;
    localparam int IN_W     = 8;
    localparam int OUT_W    = 16;

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_NONE   = 2'd0,
        CMD_UNLOCK = 2'd1,
        CMD_OPEN   = 2'd2,
        CMD_RSVD   = 2'd3
    } t_cmd;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HOLD_TIME     = 3'd0,
        REG_REWAIT_TIME   = 3'd1,
        REG_MOTOR_TIMEOUT = 3'd2,
        REG_UNLOCK_TIME   = 3'd3,
        REG_RETRY_LIMIT   = 3'd4
    } t_reg_idx;

    // door codes in the low nibble of the status byte
    typedef enum logic [3:0] {
        DOOR_CLOSED  = 4'd0,
        DOOR_OPENING = 4'd1,
        DOOR_OPEN    = 4'd2,
        DOOR_CLOSING = 4'd3,
        DOOR_UNKNOWN = 4'd4,
        DOOR_BOTH    = 4'd5
    } t_door_code;

    localparam logic [CFG_W-1:0]   HOLD_RST    = 16'd8000;
    localparam logic [CFG_W-1:0]   REWAIT_RST  = 16'd5000;
    localparam logic [CFG_W-1:0]   TIMEOUT_RST = 16'd3000;
    localparam logic [CFG_W-1:0]   UNLOCK_RST  = 16'd500;
    localparam logic [RETRY_W-1:0] LIMIT_RST   = 4'd5;
    localparam logic [RETRY_W-1:0] RETRY_SAT   = 4'd10;

    // one result beat
    typedef struct packed {
        logic                changed;
        logic [STATUS_W-1:0] status;
        logic                close_on;
        logic                open_on;
        logic                lock_rel;
    } t_result;

endpackage

@@ sv/door_motor_sequencer_unit.sv @@
// ----------------------------------------------------------------------------
// door_motor_sequencer_unit
// Door lock and motor sequencer: timed lock release, open and close motor
// drive with timeouts, automatic close after dwell, open and close retries.
// ----------------------------------------------------------------------------
// result: registered, appearing in the cycle after its input beat is taken
// throughput: one beat per cycle unless the sink stalls; all timer and retry
//   updates for a beat come from next-state logic ahead of the state registers
// reset (i_rst_n low, synchronous): timers and retry counts cleared, motors
//   off, lock engaged, registers back to their presets, output register empty
module door_motor_sequencer_unit
    import dms_pkg::*;
#(
    parameter int TIMER_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // config write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    // input stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // command[1:0], closed_sensor[2], open_sensor[3], lock_sensor[4],
    // pinch_button[5], tick[6], zero[7]
    input  logic [IN_W-1:0]      s_axis_tdata,
    // result stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // lock_release[0], open_motor_on[1], close_motor_on[2], status_byte[10:3],
    // status_changed[11], zero[15:12]
    output logic [OUT_W-1:0]     m_axis_tdata
);

    localparam int TB = TIMER_BITS;
    localparam int CW = (TB > CFG_W) ? TB : CFG_W;

    typedef logic [TB-1:0] t_tmr;

    // configuration
    logic [CFG_W-1:0]   r_hold, r_rewait, r_timeout, r_unlock;
    logic [RETRY_W-1:0] r_limit;

    // sequencer state
    t_tmr r_unlock_tmr, r_omot_tmr, r_cmot_tmr, r_dwell_tmr, r_ophase_tmr, r_cphase_tmr;
    t_tmr n_unlock_tmr, n_omot_tmr, n_cmot_tmr, n_dwell_tmr, n_ophase_tmr, n_cphase_tmr;
    logic [RETRY_W-1:0] r_oretry, r_cretry, n_oretry, n_cretry;
    logic r_drv_lock, r_drv_open, r_drv_close;
    logic n_drv_lock, n_drv_open, n_drv_close;
    logic [STATUS_W-1:0] r_last_status, n_status;
    logic n_changed;

    // output register
    logic    r_out_valid;
    t_result r_out;

    // input beat fields
    t_cmd in_cmd;
    logic in_closed, in_opened, in_lock, in_pinch, in_tick;
    logic in_accept;

    assign in_cmd    = t_cmd'(s_axis_tdata[1:0]);
    assign in_closed = s_axis_tdata[2];
    assign in_opened = s_axis_tdata[3];
    assign in_lock   = s_axis_tdata[4];
    assign in_pinch  = s_axis_tdata[5];
    assign in_tick   = s_axis_tdata[6];

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_W - $bits(t_result)){1'b0}}, r_out};

    function automatic t_tmr tinc(input t_tmr t);
        return (t != '0) ? t + t_tmr'(1) : '0;
    endfunction

    function automatic logic gt_cfg(input t_tmr t, input logic [CFG_W-1:0] c);
        return CW'(t) > CW'(c);
    endfunction

    function automatic logic below_lim(input logic [RETRY_W-1:0] cnt,
                                       input logic [RETRY_W-1:0] lim);
        return ({1'b0, cnt} + 5'd1) < {1'b0, lim};
    endfunction

    function automatic logic [RETRY_W-1:0] sat_inc(input logic [RETRY_W-1:0] c);
        return (c >= RETRY_SAT) ? RETRY_SAT : c + RETRY_W'(1);
    endfunction

    always_comb begin
        t_door_code code;
        t_tmr       rewait_t;

        rewait_t = t_tmr'(r_rewait);

        n_unlock_tmr = r_unlock_tmr;
        n_omot_tmr   = r_omot_tmr;
        n_cmot_tmr   = r_cmot_tmr;
        n_dwell_tmr  = r_dwell_tmr;
        n_ophase_tmr = r_ophase_tmr;
        n_cphase_tmr = r_cphase_tmr;
        n_oretry     = r_oretry;
        n_cretry     = r_cretry;
        n_drv_lock   = r_drv_lock;
        n_drv_open   = r_drv_open;
        n_drv_close  = r_drv_close;

        if (in_tick) begin
            n_unlock_tmr = tinc(n_unlock_tmr);
            n_omot_tmr   = tinc(n_omot_tmr);
            n_cmot_tmr   = tinc(n_cmot_tmr);
            n_dwell_tmr  = tinc(n_dwell_tmr);
            n_ophase_tmr = tinc(n_ophase_tmr);
            n_cphase_tmr = tinc(n_cphase_tmr);
        end

        case (in_cmd)
            CMD_UNLOCK: begin
                n_drv_lock   = 1'b1;
                n_unlock_tmr = t_tmr'(1);
            end
            CMD_OPEN: begin
                n_drv_close  = 1'b0;
                n_drv_open   = 1'b1;
                n_omot_tmr   = t_tmr'(1);
                n_dwell_tmr  = t_tmr'(1);
                n_ophase_tmr = t_tmr'(1);
                n_oretry     = '0;
                n_cretry     = '0;
            end
            default: ;
        endcase

        // status is formed after the command, before the sequencing rules
        if (in_closed && in_opened)
            code = DOOR_BOTH;
        else if (in_closed)
            code = DOOR_CLOSED;
        else if (in_opened)
            code = DOOR_OPEN;
        else if (n_omot_tmr != '0 && CW'(n_omot_tmr) < CW'(r_timeout))
            code = DOOR_OPENING;
        else if (n_cmot_tmr != '0 && CW'(n_cmot_tmr) < CW'(r_timeout))
            code = DOOR_CLOSING;
        else
            code = DOOR_UNKNOWN;
        n_status  = {3'b000, in_lock, code};
        n_changed = n_status != r_last_status;

        if (in_pinch) begin
            if (!in_opened) begin
                n_drv_close  = 1'b0;
                n_drv_open   = 1'b1;
                n_omot_tmr   = t_tmr'(1);
                n_dwell_tmr  = t_tmr'(1);
                n_ophase_tmr = t_tmr'(1);
                n_cmot_tmr   = '0;
                n_cphase_tmr = '0;
            end else begin
                n_dwell_tmr  = rewait_t;
                n_ophase_tmr = '0;
                n_drv_open   = 1'b0;
            end
            n_oretry = '0;
            n_cretry = '0;
        end

        if (gt_cfg(n_unlock_tmr, r_unlock)) begin
            n_unlock_tmr = '0;
            n_drv_lock   = 1'b0;
        end
        if (gt_cfg(n_omot_tmr, r_timeout)) begin
            n_omot_tmr = '0;
            n_drv_open = 1'b0;
        end
        // automatic close after the dwell time
        if (gt_cfg(n_dwell_tmr, r_hold)) begin
            n_dwell_tmr  = '0;
            n_drv_open   = 1'b0;
            n_drv_close  = 1'b1;
            n_cmot_tmr   = t_tmr'(1);
            n_cphase_tmr = t_tmr'(1);
        end
        if (gt_cfg(n_cmot_tmr, r_timeout)) begin
            n_cmot_tmr  = '0;
            n_drv_close = 1'b0;
        end

        // door reached fully open
        if (n_omot_tmr != '0 && in_opened) begin
            n_dwell_tmr  = below_lim(n_cretry, r_limit) ? rewait_t : '0;
            n_ophase_tmr = '0;
            n_drv_open   = 1'b0;
            n_oretry     = '0;
        end

        if (gt_cfg(n_ophase_tmr, r_hold)) begin
            n_ophase_tmr = '0;
            if (!in_opened) begin
                if (below_lim(n_oretry, r_limit)) begin
                    n_drv_close  = 1'b0;
                    n_drv_open   = 1'b1;
                    n_omot_tmr   = t_tmr'(1);
                    n_dwell_tmr  = t_tmr'(1);
                    n_ophase_tmr = t_tmr'(1);
                end
                n_oretry = sat_inc(n_oretry);
            end
        end

        // door reached closed
        if (n_cmot_tmr != '0 && in_closed) begin
            n_cmot_tmr   = '0;
            n_drv_close  = 1'b0;
            n_cretry     = '0;
            n_cphase_tmr = '0;
        end

        if (gt_cfg(n_cphase_tmr, r_rewait)) begin
            n_cphase_tmr = '0;
            if (!in_closed) begin
                n_drv_close = 1'b0;
                n_drv_open  = 1'b1;
                n_omot_tmr  = t_tmr'(1);
                if (below_lim(n_cretry, r_limit)) begin
                    n_dwell_tmr  = t_tmr'(1);
                    n_ophase_tmr = t_tmr'(1);
                    n_oretry     = '0;
                end else begin
                    // give up closing, leave the door open
                    n_dwell_tmr  = '0;
                    n_ophase_tmr = '0;
                end
                n_cretry = sat_inc(n_cretry);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold    <= HOLD_RST;
            r_rewait  <= REWAIT_RST;
            r_timeout <= TIMEOUT_RST;
            r_unlock  <= UNLOCK_RST;
            r_limit   <= LIMIT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_HOLD_TIME:     r_hold    <= i_cfg_data;
                REG_REWAIT_TIME:   r_rewait  <= i_cfg_data;
                REG_MOTOR_TIMEOUT: r_timeout <= i_cfg_data;
                REG_UNLOCK_TIME:   r_unlock  <= i_cfg_data;
                REG_RETRY_LIMIT:   r_limit   <= i_cfg_data[RETRY_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unlock_tmr  <= '0;
            r_omot_tmr    <= '0;
            r_cmot_tmr    <= '0;
            r_dwell_tmr   <= '0;
            r_ophase_tmr  <= '0;
            r_cphase_tmr  <= '0;
            r_oretry      <= '0;
            r_cretry      <= '0;
            r_drv_lock    <= 1'b0;
            r_drv_open    <= 1'b0;
            r_drv_close   <= 1'b0;
            r_last_status <= '0;
        end else if (in_accept) begin
            r_unlock_tmr  <= n_unlock_tmr;
            r_omot_tmr    <= n_omot_tmr;
            r_cmot_tmr    <= n_cmot_tmr;
            r_dwell_tmr   <= n_dwell_tmr;
            r_ophase_tmr  <= n_ophase_tmr;
            r_cphase_tmr  <= n_cphase_tmr;
            r_oretry      <= n_oretry;
            r_cretry      <= n_cretry;
            r_drv_lock    <= n_drv_lock;
            r_drv_open    <= n_drv_open;
            r_drv_close   <= n_drv_close;
            r_last_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out.lock_rel <= n_drv_lock;
            r_out.open_on  <= n_drv_open;
            r_out.close_on <= n_drv_close;
            r_out.status   <= n_status;
            r_out.changed  <= n_changed;
        end
    end

    // both motors are never driven together
    a_motor_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_drv_open && r_drv_close))
        else $error("open and close motors driven together");

    // retry counts saturate
    a_retry_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_oretry <= RETRY_SAT && r_cretry <= RETRY_SAT)
        else $error("retry count beyond saturation");

    // an accepted beat always leaves a result in the output register
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_out_valid && r_out.status == r_last_status))
        else $error("accepted beat without matching result");

    // result drive bits follow the drive state
    a_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_out.open_on == r_drv_open && r_out.close_on == r_drv_close
                       && r_out.lock_rel == r_drv_lock))
        else $error("result drive differs from drive state");

endmodule

@@ tb/dms_door_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dms_door_checker
// Passive checker for the door motor sequencer. It tracks register writes,
// runs its own model of the lock, motor, dwell and retry timers on every
// accepted input beat, and compares every result beat, field by field,
// against the oldest expected result.
// ----------------------------------------------------------------------------
module dms_door_checker
    import dms_pkg::*;
#(
    parameter int TIMER_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tready,
    input  logic [IN_W-1:0]      i_s_tdata,
    input  logic                 i_m_tvalid,
    input  logic                 i_m_tready,
    input  logic [OUT_W-1:0]     i_m_tdata,
    output int                   o_mismatches,
    output int                   o_pending
);

    typedef logic [TIMER_BITS-1:0] t_timer;

    localparam int MAX_REPORTS = 10;

    logic [CFG_W-1:0]   hold_time_q;
    logic [CFG_W-1:0]   rewait_time_q;
    logic [CFG_W-1:0]   motor_timeout_q;
    logic [CFG_W-1:0]   unlock_time_q;
    logic [RETRY_W-1:0] retry_limit_q;

    t_timer unlock_tmr, open_motor_tmr, close_motor_tmr;
    t_timer dwell_tmr, open_phase_tmr, close_phase_tmr;
    logic [RETRY_W-1:0]  open_retries, close_retries;
    logic                lock_released, open_drive, close_drive;
    logic [STATUS_W-1:0] last_status;

    t_result door_expect_q[$];
    int      mismatch_count = 0;

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
    end

    function automatic void clear_door_model();
        hold_time_q     = HOLD_RST;
        rewait_time_q   = REWAIT_RST;
        motor_timeout_q = TIMEOUT_RST;
        unlock_time_q   = UNLOCK_RST;
        retry_limit_q   = LIMIT_RST;
        unlock_tmr      = '0;
        open_motor_tmr  = '0;
        close_motor_tmr = '0;
        dwell_tmr       = '0;
        open_phase_tmr  = '0;
        close_phase_tmr = '0;
        open_retries    = '0;
        close_retries   = '0;
        lock_released   = 1'b0;
        open_drive      = 1'b0;
        close_drive     = 1'b0;
        last_status     = '0;
    endfunction

    // idle timers stay at zero, running ones wrap silently
    function automatic t_timer step_timer(input t_timer t);
        return (t != '0) ? t_timer'(t + 1'b1) : '0;
    endfunction

    // signed compare, so a limit of zero refuses every retry
    function automatic bit under_retry_limit(input logic [RETRY_W-1:0] count);
        return int'(count) < int'(retry_limit_q) - 1;
    endfunction

    function automatic logic [RETRY_W-1:0] bump_retry(input logic [RETRY_W-1:0] count);
        return (count >= RETRY_SAT) ? RETRY_SAT : RETRY_W'(count + 1'b1);
    endfunction

    function automatic void begin_opening();
        close_drive    = 1'b0;
        open_drive     = 1'b1;
        open_motor_tmr = t_timer'(1);
        dwell_tmr      = t_timer'(1);
        open_phase_tmr = t_timer'(1);
    endfunction

    function automatic t_result predict_door_pass(input logic [IN_W-1:0] beat);
        t_cmd                cmd;
        logic                closed, opened, lock, pinch, tick;
        t_door_code          code;
        logic [STATUS_W-1:0] status;
        t_result             res;
        cmd    = t_cmd'(beat[1:0]);
        closed = beat[2];
        opened = beat[3];
        lock   = beat[4];
        pinch  = beat[5];
        tick   = beat[6];

        if (tick) begin
            unlock_tmr      = step_timer(unlock_tmr);
            open_motor_tmr  = step_timer(open_motor_tmr);
            close_motor_tmr = step_timer(close_motor_tmr);
            dwell_tmr       = step_timer(dwell_tmr);
            close_phase_tmr = step_timer(close_phase_tmr);
            open_phase_tmr  = step_timer(open_phase_tmr);
        end

        if (cmd == CMD_UNLOCK) begin
            lock_released = 1'b1;
            unlock_tmr    = t_timer'(1);
        end else if (cmd == CMD_OPEN) begin
            begin_opening();
            open_retries  = '0;
            close_retries = '0;
        end

        if (closed && opened) begin
            code = DOOR_BOTH;
        end else if (closed) begin
            code = DOOR_CLOSED;
        end else if (opened) begin
            code = DOOR_OPEN;
        end else if (open_motor_tmr != '0 && open_motor_tmr < motor_timeout_q) begin
            code = DOOR_OPENING;
        end else if (close_motor_tmr != '0 && close_motor_tmr < motor_timeout_q) begin
            code = DOOR_CLOSING;
        end else begin
            code = DOOR_UNKNOWN;
        end
        status      = {3'b000, lock, code};
        res.changed = (status != last_status);
        res.status  = status;
        last_status = status;

        if (pinch) begin
            if (!opened) begin
                begin_opening();
                close_motor_tmr = '0;
                close_phase_tmr = '0;
            end else begin
                dwell_tmr      = t_timer'(rewait_time_q);
                open_phase_tmr = '0;
                open_drive     = 1'b0;
            end
            open_retries  = '0;
            close_retries = '0;
        end

        if (unlock_tmr > unlock_time_q) begin
            unlock_tmr    = '0;
            lock_released = 1'b0;
        end
        if (open_motor_tmr > motor_timeout_q) begin
            open_motor_tmr = '0;
            open_drive     = 1'b0;
        end
        // dwell over: start the automatic close
        if (dwell_tmr > hold_time_q) begin
            dwell_tmr       = '0;
            open_drive      = 1'b0;
            close_drive     = 1'b1;
            close_motor_tmr = t_timer'(1);
            close_phase_tmr = t_timer'(1);
        end
        if (close_motor_tmr > motor_timeout_q) begin
            close_motor_tmr = '0;
            close_drive     = 1'b0;
        end

        if (open_motor_tmr != '0 && opened) begin
            dwell_tmr      = under_retry_limit(close_retries) ? t_timer'(rewait_time_q) : '0;
            open_phase_tmr = '0;
            open_drive     = 1'b0;
            open_retries   = '0;
        end

        if (open_phase_tmr > hold_time_q) begin
            open_phase_tmr = '0;
            if (!opened) begin
                if (under_retry_limit(open_retries)) begin
                    begin_opening();
                end
                open_retries = bump_retry(open_retries);
            end
        end

        if (close_motor_tmr != '0 && closed) begin
            close_motor_tmr = '0;
            close_drive     = 1'b0;
            close_retries   = '0;
            close_phase_tmr = '0;
        end

        if (close_phase_tmr > rewait_time_q) begin
            close_phase_tmr = '0;
            if (!closed) begin
                if (under_retry_limit(close_retries)) begin
                    begin_opening();
                    open_retries = '0;
                end else begin
                    // out of close attempts: leave the door open
                    close_drive    = 1'b0;
                    open_drive     = 1'b1;
                    open_motor_tmr = t_timer'(1);
                    dwell_tmr      = '0;
                    open_phase_tmr = '0;
                end
                close_retries = bump_retry(close_retries);
            end
        end

        res.lock_rel = lock_released;
        res.open_on  = open_drive;
        res.close_on = close_drive;
        return res;
    endfunction

    task automatic flag_mismatch(input string what, input logic [15:0] want,
                                 input logic [15:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_result got, want;
        if (!i_rst_n) begin
            clear_door_model();
            door_expect_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_reg_idx'(i_cfg_index))
                    REG_HOLD_TIME:     hold_time_q     = i_cfg_data;
                    REG_REWAIT_TIME:   rewait_time_q   = i_cfg_data;
                    REG_MOTOR_TIMEOUT: motor_timeout_q = i_cfg_data;
                    REG_UNLOCK_TIME:   unlock_time_q   = i_cfg_data;
                    REG_RETRY_LIMIT:   retry_limit_q   = i_cfg_data[RETRY_W-1:0];
                    default: ;
                endcase
            end

            // results leave before this edge's input beat can add one
            if (i_m_tvalid && i_m_tready) begin
                got = t_result'(i_m_tdata[11:0]);
                if (door_expect_q.size() == 0) begin
                    flag_mismatch("unexpected result beat", '0, i_m_tdata);
                end else begin
                    want = door_expect_q.pop_front();
                    if (got.lock_rel !== want.lock_rel)
                        flag_mismatch("lock_release", 16'(want.lock_rel),
                                      16'(got.lock_rel));
                    if (got.open_on !== want.open_on)
                        flag_mismatch("open_motor_on", 16'(want.open_on),
                                      16'(got.open_on));
                    if (got.close_on !== want.close_on)
                        flag_mismatch("close_motor_on", 16'(want.close_on),
                                      16'(got.close_on));
                    if (got.status !== want.status)
                        flag_mismatch("status_byte", 16'(want.status), 16'(got.status));
                    if (got.changed !== want.changed)
                        flag_mismatch("status_changed", 16'(want.changed),
                                      16'(got.changed));
                    if (i_m_tdata[OUT_W-1:12] !== '0)
                        flag_mismatch("pad bits", '0, 16'(i_m_tdata[OUT_W-1:12]));
                end
            end

            if (i_s_tvalid && i_s_tready) begin
                door_expect_q.push_back(predict_door_pass(i_s_tdata));
            end
        end
        o_pending    <= door_expect_q.size();
        o_mismatches <= mismatch_count;
    end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Regression for door_motor_sequencer_unit. Drives directed and random
// controller passes from a simple door plant that follows the motor outputs,
// reprograms the timing registers between phases, varies source and sink
// back-pressure, and takes the verdict from the attached checker.
// ----------------------------------------------------------------------------
module tb_top;
    import dms_pkg::*;

    localparam int TB_TIMER_BITS = 16;
    localparam int CLK_HIGH_NS   = 6;
    localparam int CLK_LOW_NS    = 6;
    localparam int DOOR_TRAVEL   = 6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_IDX = 3'd7;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [IN_W-1:0]      s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [OUT_W-1:0]     m_axis_tdata;

    int mismatches;
    int pending;

    int sender_idle_pct   = 0;
    int receiver_stall_pct = 0;
    int long_stall_request = 0;
    int stall_left         = 0;

    // door plant
    int      door_pos    = 0;
    bit      door_jammed = 1'b0;
    logic    lock_level  = 1'b0;
    t_result last_drive  = '0;

    door_motor_sequencer_unit #(
        .TIMER_BITS(TB_TIMER_BITS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    dms_door_checker #(
        .TIMER_BITS(TB_TIMER_BITS)
    ) checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (s_axis_tvalid),
        .i_s_tready  (s_axis_tready),
        .i_s_tdata   (s_axis_tdata),
        .i_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .i_m_tdata   (m_axis_tdata),
        .o_mismatches(mismatches),
        .o_pending   (pending)
    );

    always begin
        #(CLK_LOW_NS) i_clk = 1'b1;
        #(CLK_HIGH_NS) i_clk = 1'b0;
    end

    initial begin
        #(10_000_000);
        $display("door_motor_sequencer_unit regression: fail");
        $finish;
    end

    // sink side: random stalls, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (long_stall_request > 0) begin
            stall_left         = long_stall_request;
            long_stall_request = 0;
        end
        if (stall_left > 0) begin
            stall_left    = stall_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // the plant moves the door by the last motor drive seen on the result bus
    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) begin
            last_drive <= t_result'(m_axis_tdata[11:0]);
        end
    end

    function automatic logic [IN_W-1:0] make_beat(input t_cmd cmd, input logic closed,
                                                  input logic opened, input logic lock,
                                                  input logic pinch, input logic tick);
        return {1'b0, tick, pinch, lock, opened, closed, cmd};
    endfunction

    function automatic logic [IN_W-1:0] next_door_beat();
        t_cmd cmd;
        logic tick, closed, opened, pinch;
        int   roll;
        roll = $urandom_range(99);
        cmd  = (roll < 4) ? CMD_OPEN : (roll < 8) ? CMD_UNLOCK :
               (roll < 10) ? CMD_RSVD : CMD_NONE;
        tick = ($urandom_range(99) < 70);
        if ($urandom_range(99) < 2) begin
            door_jammed = !door_jammed;
        end
        if (tick && !door_jammed) begin
            if (last_drive.open_on && door_pos < DOOR_TRAVEL) begin
                door_pos++;
            end else if (last_drive.close_on && door_pos > 0) begin
                door_pos--;
            end
        end
        closed = (door_pos == 0);
        opened = (door_pos == DOOR_TRAVEL);
        // switch noise, including both switches at once
        if ($urandom_range(99) < 8) begin
            closed = 1'($urandom_range(1));
            opened = 1'($urandom_range(1));
        end
        if ($urandom_range(99) < 10) begin
            lock_level = !lock_level;
        end
        pinch = ($urandom_range(99) < 3);
        return make_beat(cmd, closed, opened, lock_level, pinch, tick);
    endfunction

    // leaves tvalid high so back-to-back beats need no low cycle
    task automatic send_door_beat(input logic [IN_W-1:0] beat);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= beat;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic wait_idle();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic program_registers(input logic [CFG_W-1:0] hold, input logic [CFG_W-1:0] rewait,
                                     input logic [CFG_W-1:0] tmo, input logic [CFG_W-1:0] unl,
                                     input logic [CFG_W-1:0] limit);
        wait_idle();
        write_reg(REG_HOLD_TIME, hold);
        write_reg(REG_REWAIT_TIME, rewait);
        write_reg(REG_MOTOR_TIMEOUT, tmo);
        write_reg(REG_UNLOCK_TIME, unl);
        write_reg(REG_RETRY_LIMIT, limit);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_door_phase(input int n_items, input int idle_pct, input int stall_pct);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        repeat (n_items) send_door_beat(next_door_beat());
        s_axis_tvalid <= 1'b0;
    endtask

    initial begin
        int idle_mode[5];
        int stall_mode[5];
        idle_mode  = '{0, 82, 0, 38, 0};
        stall_mode = '{0, 0, 82, 38, 0};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset presets
        run_door_phase(40, 0, 0);

        // directed: short timers, masked retry limit of zero, unused index
        program_registers(16'd2, 16'd0, 16'd3, 16'd1, 16'd1);
        write_reg(REG_SPARE_IDX, 16'hFFFF);
        write_reg(REG_RETRY_LIMIT, 16'hFFF0);
        i_cfg_valid <= 1'b0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 50;
        send_door_beat(make_beat(CMD_NONE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        send_door_beat(make_beat(CMD_RSVD, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1));
        send_door_beat(make_beat(CMD_UNLOCK, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1));
        send_door_beat(make_beat(CMD_NONE, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1));
        send_door_beat(make_beat(CMD_OPEN, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1));
        send_door_beat(make_beat(CMD_NONE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
        send_door_beat(make_beat(CMD_NONE, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1));
        send_door_beat(make_beat(CMD_NONE, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1));
        // pinch while fully open loads a dwell preset of zero
        send_door_beat(make_beat(CMD_NONE, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1));
        send_door_beat(make_beat(CMD_NONE, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1));
        // motor timeout, then an open retry refused by the limit
        repeat (5) send_door_beat(make_beat(CMD_NONE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
        send_door_beat(make_beat(CMD_OPEN, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        // automatic close, then close retry refused: door left open
        repeat (4) send_door_beat(make_beat(CMD_NONE, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1));
        send_door_beat(make_beat(CMD_NONE, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1));
        send_door_beat(make_beat(CMD_RSVD, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
        s_axis_tvalid <= 1'b0;

        for (int k = 0; k < 5; k++) begin
            program_registers(CFG_W'($urandom_range(1, 20)), CFG_W'($urandom_range(0, 16)),
                              CFG_W'($urandom_range(1, 12)), CFG_W'($urandom_range(0, 10)),
                              CFG_W'($urandom_range(1, 9)));
            if (k == 4) begin
                // hold the sink off so the block backs up into the source
                long_stall_request = 400;
            end
            run_door_phase((k == 4) ? 80 : 120, idle_mode[k], stall_mode[k]);
        end

        program_registers(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd9);
        run_door_phase(60, 38, 38);
        program_registers(16'd0, 16'd0, 16'd1, 16'd0, 16'd1);
        run_door_phase(100, 0, 0);
        program_registers(16'd1, 16'd2, 16'd0, 16'd0, 16'd15);
        run_door_phase(60, 82, 82);

        wait_idle();
        repeat (4) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("door_motor_sequencer_unit regression: pass");
        end else begin
            $display("door_motor_sequencer_unit regression: fail");
        end
        $finish;
    end

endmodule
